@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/buddy_pkg.sv @@
`default_nettype none

package buddy_pkg;

    localparam int LVW = 5;
    localparam logic [LVW-1:0] LEVEL_NONE = 5'd31;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_LEV_INC,
        CMD_POP_READ,
        CMD_POP_REMOVE,
        CMD_SPLIT_PUSH,
        CMD_SPLIT_MARK,
        CMD_UNIT_READ,
        CMD_FREE_TAKE,
        CMD_BUDDY_READ,
        CMD_MERGE_REMOVE,
        CMD_MERGE_CLR,
        CMD_PUSH,
        CMD_RES_OK,
        CMD_RES_FAIL,
        CMD_RES_FREE
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_POP_REMOVE,
        ST_SPLIT_PUSH,
        ST_SPLIT_MARK,
        ST_FREE_READ,
        ST_FREE_CHECK,
        ST_BUDDY_READ,
        ST_BUDDY_CHECK,
        ST_MERGE_CLR,
        ST_PUSH,
        ST_RES_OK,
        ST_RES_FAIL,
        ST_RES_FREE
    } ctrl_state_t;

    typedef struct packed {
        logic clear_done;
        logic mode;
        logic oversize;
        logic out_of_pool;
        logic lev_over;
        logic lev_empty;
        logic lev_gt_need;
        logic bad_free;
        logic rd_top;
        logic lev_next_top;
        logic buddy_free;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/buddy_allocator.sv @@
`default_nettype none

// binary buddy allocator over a pool of 2^POOL_LEVEL bytes in blocks of at
// least 2^MIN_LEVEL bytes (POOL_LEVEL above MIN_LEVEL). one input beat is an
// allocate (tuser 0, size in tdata) or a free (tuser 1, offset in tdata);
// each gives one result beat with the block offset (zero for a free) and
// a fail flag. after reset the unit table is swept before the first beat
// is taken. items are handled one at a time by a sequencer over the
// single-port unit and link tables: an allocate searches upward past
// empty levels, then splits down to the needed level; a free checks the
// unit, then merges with free buddies level by level before it pushes
// the block. a finished result waits in the output register while the
// next beat enters.

module buddy_allocator
    import buddy_pkg::*;
#(
    parameter int MIN_LEVEL  = 4,
    parameter int POOL_LEVEL = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // request_size[16:0], free_address[32:17], zero pad
    input  wire logic [0:0]  s_tuser,   // mode[0]: 0 allocate, 1 free
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // block_address[15:0]
    output logic [0:0]       m_tuser    // status[0]: 1 out of memory or too large
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer for search, split and merge steps
    buddy_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, free lists and result register
    buddy_dp #(
        .MIN_LEVEL  (MIN_LEVEL),
        .POOL_LEVEL (POOL_LEVEL)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ rtl/buddy_dp.sv @@
`default_nettype none
`include "assert_macros.svh"

module buddy_dp
    import buddy_pkg::*;
#(
    parameter int MIN_LEVEL  = 4,
    parameter int POOL_LEVEL = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire logic [39:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    output dp_status_t       status,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic [0:0]       m_tuser
);

    localparam int UW         = POOL_LEVEL - MIN_LEVEL;
    localparam int NUM_UNITS  = 1 << UW;
    localparam int NUM_LEVELS = UW + 1;
    localparam int LIW        = $clog2(NUM_LEVELS);
    localparam logic [LVW-1:0] MINL = LVW'(MIN_LEVEL);
    localparam logic [LVW-1:0] POOLL = LVW'(POOL_LEVEL);

    // unit store: {listed, level}
    logic [LVW:0]    unit_mem [NUM_UNITS];
    logic [UW-1:0]   next_mem [NUM_UNITS];
    logic [UW-1:0]   prev_mem [NUM_UNITS];

    logic [UW-1:0]   head_reg [NUM_LEVELS];
    logic [UW-1:0]   tail_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] vld_reg;

    logic [UW-1:0]   clr_cnt_reg;
    logic            clear_done_reg;
    logic            mode_reg, oversize_reg, oop_reg;
    logic [LVW-1:0]  need_reg, lev_reg;
    logic [UW-1:0]   u_reg, tgt_reg;
    logic [LVW:0]    unit_rd_reg;
    logic [UW-1:0]   next_rd_reg, prev_rd_reg;
    logic            m_tvalid_reg, m_stat_reg;
    logic [15:0]     m_addr_reg;

    // request decode
    logic [16:0]     req_n, req_m;
    logic [LVW-1:0]  bitlen, need_c;
    logic [31:0]     addr_units;

    always_comb begin
        req_n  = (s_tdata[16:0] == 17'd0) ? 17'd1 : s_tdata[16:0];
        req_m  = req_n - 17'd1;
        bitlen = '0;
        for (int i = 0; i < 17; i++) begin
            if (req_m[i]) bitlen = LVW'(i + 1);
        end
        need_c     = (bitlen < MINL) ? MINL : bitlen;
        addr_units = 32'(s_tdata[32:17]) >> MIN_LEVEL;
    end

    logic [LIW-1:0] li, lip;
    logic [UW-1:0]  bit_u;
    logic           lev_ok;
    logic [LVW-1:0] rd_lvl;
    logic           rd_listed;
    logic           is_head, is_tail;

    assign li        = LIW'(lev_reg - MINL);
    assign lip       = LIW'(lev_reg - MINL - 5'd1);
    assign bit_u     = UW'(1) << (lev_reg - MINL);
    assign lev_ok    = (lev_reg >= MINL) && (lev_reg <= POOLL);
    assign rd_lvl    = unit_rd_reg[LVW-1:0];
    assign rd_listed = unit_rd_reg[LVW];
    assign is_head   = (head_reg[li] == tgt_reg);
    assign is_tail   = (tail_reg[li] == tgt_reg);

    // write port controls
    logic           um_we, nx_we, pv_we, hd_we, tl_we, vd_we;
    logic [UW-1:0]  um_wa, nx_wa, pv_wa, nx_wd, pv_wd, hd_wd, tl_wd;
    logic [LVW:0]   um_wd;
    logic [LIW-1:0] ht_li;
    logic           vd_wd;
    logic           rd_en;
    logic [UW-1:0]  rd_addr;
    logic           push_en, rem_en;
    logic [LIW-1:0] push_li;
    logic [LVW-1:0] push_lev;
    logic           res_we, res_stat;
    logic [15:0]    res_addr;
    logic [31:0]    u_bytes;

    assign u_bytes = 32'(u_reg) << MIN_LEVEL;

    always_comb begin
        um_we = 1'b0; um_wa = u_reg; um_wd = '0;
        nx_we = 1'b0; nx_wa = u_reg; nx_wd = '0;
        pv_we = 1'b0; pv_wa = u_reg; pv_wd = '0;
        hd_we = 1'b0; hd_wd = '0;
        tl_we = 1'b0; tl_wd = '0;
        vd_we = 1'b0; vd_wd = 1'b0;
        ht_li = li;
        rd_en = 1'b0; rd_addr = u_reg;
        push_en = 1'b0; push_li = li; push_lev = lev_reg;
        rem_en = 1'b0;
        res_we = 1'b0; res_stat = 1'b0; res_addr = '0;
        case (cmd)
            CMD_CLEAR: begin
                um_we = 1'b1;
                um_wa = clr_cnt_reg;
                um_wd = (clr_cnt_reg == '0) ? {1'b1, POOLL} : {1'b0, LEVEL_NONE};
            end
            CMD_POP_READ: begin
                rd_en   = 1'b1;
                rd_addr = tail_reg[li];
            end
            CMD_UNIT_READ: begin
                rd_en = 1'b1;
            end
            CMD_BUDDY_READ: begin
                rd_en   = 1'b1;
                rd_addr = u_reg ^ bit_u;
            end
            CMD_POP_REMOVE: begin
                rem_en = 1'b1;
                um_we  = 1'b1; um_wa = tgt_reg; um_wd = {1'b0, lev_reg};
            end
            CMD_MERGE_REMOVE: begin
                rem_en = 1'b1;
                um_we  = 1'b1; um_wa = tgt_reg; um_wd = {1'b0, LEVEL_NONE};
            end
            CMD_MERGE_CLR: begin
                um_we = 1'b1; um_wd = {1'b0, LEVEL_NONE};
            end
            CMD_SPLIT_PUSH: begin
                push_en = 1'b1; push_li = lip; push_lev = lev_reg - 5'd1;
            end
            CMD_SPLIT_MARK: begin
                um_we = 1'b1; um_wa = u_reg + bit_u; um_wd = {1'b0, lev_reg};
            end
            CMD_PUSH: begin
                push_en = 1'b1;
            end
            CMD_RES_OK: begin
                res_we = 1'b1; res_addr = u_bytes[15:0];
            end
            CMD_RES_FAIL: begin
                res_we = 1'b1; res_stat = 1'b1;
            end
            CMD_RES_FREE: begin
                res_we = 1'b1;
            end
            default: begin
            end
        endcase

        // unlink a listed unit using its fetched links
        if (rem_en) begin
            if (is_head && is_tail) begin
                vd_we = 1'b1; vd_wd = 1'b0;
            end else if (is_head) begin
                hd_we = 1'b1; hd_wd = next_rd_reg;
            end else if (is_tail) begin
                tl_we = 1'b1; tl_wd = prev_rd_reg;
            end else begin
                nx_we = 1'b1; nx_wa = prev_rd_reg; nx_wd = next_rd_reg;
                pv_we = 1'b1; pv_wa = next_rd_reg; pv_wd = prev_rd_reg;
            end
        end

        // insert at the head of a level list
        if (push_en) begin
            ht_li = push_li;
            um_we = 1'b1; um_wa = u_reg; um_wd = {1'b1, push_lev};
            hd_we = 1'b1; hd_wd = u_reg;
            if (!vld_reg[push_li]) begin
                vd_we = 1'b1; vd_wd = 1'b1;
                tl_we = 1'b1; tl_wd = u_reg;
            end else begin
                nx_we = 1'b1; nx_wa = u_reg; nx_wd = head_reg[push_li];
                pv_we = 1'b1; pv_wa = head_reg[push_li]; pv_wd = u_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (um_we) unit_mem[um_wa] <= um_wd;
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        if (rd_en) begin
            unit_rd_reg <= unit_mem[rd_addr];
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
            tgt_reg     <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            vld_reg            <= '0;
            vld_reg[NUM_LEVELS-1] <= 1'b1;
        end else begin
            if (hd_we) head_reg[ht_li] <= hd_wd;
            if (tl_we) tail_reg[ht_li] <= tl_wd;
            if (vd_we) vld_reg[ht_li]  <= vd_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            clear_done_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd == CMD_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + UW'(1);
                if (clr_cnt_reg == '1) clear_done_reg <= 1'b1;
            end
            if (res_we) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_LOAD: begin
                mode_reg     <= s_tuser[0];
                need_reg     <= need_c;
                lev_reg      <= need_c;
                oversize_reg <= (need_c > POOLL);
                oop_reg      <= (addr_units >= 32'(NUM_UNITS));
                u_reg        <= addr_units[UW-1:0];
            end
            CMD_LEV_INC:    lev_reg <= lev_reg + 5'd1;
            CMD_POP_READ:   u_reg   <= tail_reg[li];
            CMD_SPLIT_PUSH: lev_reg <= lev_reg - 5'd1;
            CMD_SPLIT_MARK: u_reg   <= u_reg + bit_u;
            CMD_FREE_TAKE:  lev_reg <= rd_lvl;
            CMD_MERGE_CLR: begin
                u_reg   <= u_reg & ~bit_u;
                lev_reg <= lev_reg + 5'd1;
            end
            default: begin
            end
        endcase
        if (res_we) begin
            m_addr_reg <= res_addr;
            m_stat_reg <= res_stat;
        end
    end

    always_comb begin
        status.clear_done   = clear_done_reg;
        status.mode         = mode_reg;
        status.oversize     = oversize_reg;
        status.out_of_pool  = oop_reg;
        status.lev_over     = !lev_ok;
        status.lev_empty    = lev_ok ? !vld_reg[li] : 1'b1;
        status.lev_gt_need  = (lev_reg > need_reg);
        status.bad_free     = (rd_lvl == LEVEL_NONE) || (rd_lvl < MINL) ||
                              (rd_lvl > POOLL) || rd_listed;
        status.rd_top       = (rd_lvl == POOLL);
        status.lev_next_top = ((lev_reg + 5'd1) == POOLL);
        status.buddy_free   = (rd_lvl == lev_reg) && rd_listed;
        status.out_free     = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_addr_reg;
    assign m_tuser[0] = m_stat_reg;

    `ASSERT_CLK(a_result_slot, aclk, aresetn, !res_we || !m_tvalid_reg || m_tready, "result overwrites a pending beat")
    `ASSERT_CLK(a_split_level, aclk, aresetn, (cmd != CMD_SPLIT_PUSH) || (lev_reg > need_reg), "split below needed level")

endmodule

`default_nettype wire

@@ rtl/buddy_ctrl.sv @@
`default_nettype none
`include "assert_macros.svh"

module buddy_ctrl
    import buddy_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_done) state_next = ST_IDLE;
                else cmd = CMD_CLEAR;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd        = CMD_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.mode) begin
                    state_next = status.out_of_pool ? ST_RES_FREE : ST_FREE_READ;
                end else begin
                    state_next = status.oversize ? ST_RES_FAIL : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (status.lev_over) begin
                    state_next = ST_RES_FAIL;
                end else if (status.lev_empty) begin
                    cmd = CMD_LEV_INC;
                end else begin
                    cmd        = CMD_POP_READ;
                    state_next = ST_POP_REMOVE;
                end
            end
            ST_POP_REMOVE: begin
                cmd        = CMD_POP_REMOVE;
                state_next = status.lev_gt_need ? ST_SPLIT_PUSH : ST_RES_OK;
            end
            ST_SPLIT_PUSH: begin
                cmd        = CMD_SPLIT_PUSH;
                state_next = ST_SPLIT_MARK;
            end
            ST_SPLIT_MARK: begin
                cmd        = CMD_SPLIT_MARK;
                state_next = status.lev_gt_need ? ST_SPLIT_PUSH : ST_RES_OK;
            end
            ST_FREE_READ: begin
                cmd        = CMD_UNIT_READ;
                state_next = ST_FREE_CHECK;
            end
            ST_FREE_CHECK: begin
                if (status.bad_free) begin
                    state_next = ST_RES_FREE;
                end else begin
                    cmd        = CMD_FREE_TAKE;
                    state_next = status.rd_top ? ST_PUSH : ST_BUDDY_READ;
                end
            end
            ST_BUDDY_READ: begin
                cmd        = CMD_BUDDY_READ;
                state_next = ST_BUDDY_CHECK;
            end
            ST_BUDDY_CHECK: begin
                if (status.buddy_free) begin
                    cmd        = CMD_MERGE_REMOVE;
                    state_next = ST_MERGE_CLR;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_MERGE_CLR: begin
                cmd        = CMD_MERGE_CLR;
                state_next = status.lev_next_top ? ST_PUSH : ST_BUDDY_READ;
            end
            ST_PUSH: begin
                cmd        = CMD_PUSH;
                state_next = ST_RES_FREE;
            end
            ST_RES_OK: begin
                if (status.out_free) begin
                    cmd        = CMD_RES_OK;
                    state_next = ST_IDLE;
                end
            end
            ST_RES_FAIL: begin
                if (status.out_free) begin
                    cmd        = CMD_RES_FAIL;
                    state_next = ST_IDLE;
                end
            end
            ST_RES_FREE: begin
                if (status.out_free) begin
                    cmd        = CMD_RES_FREE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_ready_after_clear, aclk, aresetn, !s_tready || status.clear_done, "accepting before clear pass ends")
    `ASSERT_NEXT(a_accept_decodes, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DECODE, "accepted beat not decoded")

endmodule

`default_nettype wire

@@ tb/sv/buddy_checker.sv @@
`timescale 1ns / 1ps

module buddy_checker #(
    parameter int MIN_LEVEL  = 4,
    parameter int POOL_LEVEL = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic [0:0]  m_tuser,
    output int               fail_count,
    output int               pending
);
    localparam int NUNITS = 1 << (POOL_LEVEL - MIN_LEVEL);
    localparam int NLEVELS = POOL_LEVEL - MIN_LEVEL + 1;
    localparam logic [4:0] LVL_NONE = 5'd31;
    localparam int EMPTY = NUNITS;

    typedef struct packed {
        logic [15:0] addr;
        logic        oom;
    } grant_t;

    logic [4:0] lvl_of [NUNITS];
    bit         on_list [NUNITS];
    int         nxt [NUNITS];
    int         prv [NUNITS];
    int         head [NLEVELS];
    int         tail [NLEVELS];
    grant_t     grants_due [$];

    function automatic void list_add(int lev, int u);
        int li;
        li = lev - MIN_LEVEL;
        if (head[li] == EMPTY) begin
            head[li] = u;
            tail[li] = u;
        end else begin
            nxt[u] = head[li];
            prv[head[li]] = u;
            head[li] = u;
        end
        lvl_of[u] = lev[4:0];
        on_list[u] = 1;
    endfunction

    function automatic void unlink(int lev, int u);
        int li;
        bit h;
        bit t;
        li = lev - MIN_LEVEL;
        h = head[li] == u;
        t = tail[li] == u;
        if (h && t) begin
            head[li] = EMPTY;
            tail[li] = EMPTY;
        end else if (h) begin
            head[li] = nxt[u];
        end else if (t) begin
            tail[li] = prv[u];
        end else begin
            nxt[prv[u]] = nxt[u];
            prv[nxt[u]] = prv[u];
        end
        on_list[u] = 0;
    endfunction

    task automatic release_block(logic [15:0] a);
        int u;
        int lev;
        int bud;
        u = a >> MIN_LEVEL;
        if (u >= NUNITS) return;
        lev = lvl_of[u];
        if (lev == LVL_NONE || lev < MIN_LEVEL || lev > POOL_LEVEL || on_list[u]) return;
        while (lev < POOL_LEVEL) begin
            bud = u ^ (1 << (lev - MIN_LEVEL));
            if (bud >= NUNITS || lvl_of[bud] != lev || !on_list[bud]) break;
            unlink(lev, bud);
            lvl_of[bud] = LVL_NONE;
            lvl_of[u] = LVL_NONE;
            if (bud < u) u = bud;
            lev++;
        end
        list_add(lev, u);
    endtask

    function automatic grant_t grant_block(logic [16:0] size);
        grant_t g;
        int n;
        int need;
        int lev;
        int u;
        g = '0;
        n = (size == 0) ? 1 : size;
        need = 0;
        while ((1 << need) < n) need++;
        if (need < MIN_LEVEL) need = MIN_LEVEL;
        if (need > POOL_LEVEL) begin
            g.oom = 1;
            return g;
        end
        lev = need;
        while (lev <= POOL_LEVEL && head[lev - MIN_LEVEL] == EMPTY) lev++;
        if (lev > POOL_LEVEL) begin
            g.oom = 1;
            return g;
        end
        u = tail[lev - MIN_LEVEL];
        unlink(lev, u);
        while (lev > need) begin
            lev--;
            list_add(lev, u);
            u = u + (1 << (lev - MIN_LEVEL));
            lvl_of[u] = lev[4:0];
        end
        g.addr = 16'((u << MIN_LEVEL) & 16'hFFFF);
        return g;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        for (int i = 0; i < NUNITS; i++) begin
            lvl_of[i] = LVL_NONE;
            on_list[i] = 0;
            nxt[i] = 0;
            prv[i] = 0;
        end
        for (int i = 0; i < NLEVELS; i++) begin
            head[i] = EMPTY;
            tail[i] = EMPTY;
        end
        list_add(POOL_LEVEL, 0);
    end

    assign pending = grants_due.size();

    always @(posedge aclk) begin
        grant_t g;
        if (aresetn) begin
            // result side first: the result of a beat accepted now cannot leave now
            if (m_tvalid && m_tready) begin
                if (grants_due.size() == 0) begin
                    report("unexpected beat", m_tdata, 16'h0);
                end else begin
                    g = grants_due.pop_front();
                    if (m_tdata !== g.addr) report("block_address", m_tdata, g.addr);
                    if (m_tuser[0] !== g.oom) report("status", 16'(m_tuser), 16'(g.oom));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0]) begin
                    release_block(s_tdata[32:17]);
                    grants_due.push_back('0);
                end else begin
                    grants_due.push_back(grant_block(s_tdata[16:0]));
                end
            end
        end
    end
endmodule

@@ tb/sv/tb_buddy_allocator.sv @@
`timescale 1ns / 1ps

module tb_buddy_allocator;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // request_size[16:0], free_address[32:17], zero pad
    logic [0:0]  s_tuser;    // mode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // block_address[15:0]
    logic [0:0]  m_tuser;    // status[0]
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          timed_out;
    logic [15:0] held [$];   // granted offsets and the zero offsets of free results, used to make frees

    localparam int WATCHDOG = 20000;   // covers the sweep after reset

    buddy_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    buddy_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("tb_buddy_allocator: done, errors");
            $finish;
        end
    end

    // result side: random stall per beat; grants feed the pool of offsets to free
    initial begin
        int w;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            m_tready = 0;
            repeat (w) @(negedge aclk);
            m_tready = 1;
            do @(posedge aclk); while (!m_tvalid);
            if (m_tuser[0] == 0 && m_tdata != 0 || m_tuser[0] == 0 && held.size() < 64)
                held.push_back(m_tdata);
        end
    end

    task automatic send(bit fr, logic [16:0] size, logic [15:0] addr, bit gap);
        int w;
        w = gap ? $urandom_range(0, 14) : 0;
        repeat (w) @(negedge aclk);
        s_tuser = fr;
        s_tdata = {7'b0, addr, size};
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic free_held(bit gap);
        int k;
        logic [15:0] a;
        k = $urandom_range(0, held.size() - 1);
        a = held[k];
        held.delete(k);
        send(1, 17'($urandom), a | 16'($urandom_range(0, 15)), gap);
    endtask

    initial begin
        int r;
        bit gap;
        timed_out = 0;
        idle_cycles = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: size extremes, oversize, exhaustion, odd frees
        send(0, 17'd0, 16'h0, 1);
        send(0, 17'd1, 16'h0, 1);
        send(0, 17'd16, 16'h0, 0);
        send(0, 17'd17, 16'h0, 0);
        send(0, 17'd65537, 16'h0, 1);
        send(0, 17'h1FFFF, 16'hFFFF, 0);
        send(1, 17'h1FFFF, 16'hFFFF, 1);   // unaligned, frees the block at 0xFFF0
        send(1, 17'd0, 16'h0007, 0);       // unaligned, unit zero is still on a free list
        send(0, 17'd32768, 16'h0, 0);
        send(0, 17'd32768, 16'h0, 0);
        send(0, 17'd16, 16'h0, 1);         // granted from a free 16-byte block
        send(1, 17'd0, 16'h8000, 0);
        send(1, 17'd0, 16'h8000, 0);       // already free
        send(1, 17'd0, 16'h000F, 1);       // unaligned free of the lower half, its buddy is split, no merge
        send(0, 17'd65536, 16'h0, 0);
        send(1, 17'd0, 16'h0000, 0);
        held.delete();
        // let the checker drain before random traffic
        wait (pending == 0);

        for (int i = 0; i < 1530; i++) begin
            gap = (i % 300) < 200;
            if (i == 700) wait (pending == 0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send(1'($urandom_range(0, 1)), 17'($urandom), 16'($urandom), gap);
            end else if (r < 50 && held.size() > 0) begin
                free_held(gap);
            end else if (r < 55) begin
                send(0, 17'($urandom_range(4097, 65536)), 16'($urandom), gap);
            end else begin
                send(0, 17'($urandom_range(0, 1 << $urandom_range(0, 10))), 16'($urandom), gap);
            end
        end

        wait (pending == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_buddy_allocator: done, clean");
        end else begin
            $display("tb_buddy_allocator: done, errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/buddy_pkg.sv
rtl/buddy_dp.sv
rtl/buddy_ctrl.sv
rtl/buddy_allocator.sv
tb/sv/buddy_checker.sv
tb/sv/tb_buddy_allocator.sv
